### rtl/bmcs_pkg.sv
package bmcs_pkg;

    // default sizes
    localparam int MAX_STATIONS_DEF    = 64;
    localparam int MAX_ITERATIONS_DEF  = 200;
    localparam int CDF_TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int MAG_W   = 24;
    localparam int WT_W    = 23;
    localparam int SIG_W   = 19;
    localparam int SIGU_W  = 20;
    localparam int DEV_W   = 24;
    localparam int PROB_W  = 31;
    localparam int ENT_W   = MAG_W + DEV_W;
    localparam int CFG_IDX_W = 1;

    // probabilities, Q30
    localparam logic [PROB_W-1:0] Q30_ONE  = 31'd1073741824;
    localparam logic [PROB_W-1:0] Q30_HALF = 31'd536870912;
    localparam logic [PROB_W-1:0] P_LO     = 31'd1017370378;
    localparam logic [PROB_W-1:0] P_HI     = 31'd1022739088;
    localparam logic [PROB_W-1:0] P_90     = 31'd966367642;
    localparam logic [PROB_W-1:0] P_95     = 31'd1020054733;

    // magnitude steps and limits, Q16
    localparam logic signed [27:0] STEP005 = 28'sd3277;
    localparam logic signed [27:0] STEP01  = 28'sd6554;
    localparam logic signed [MAG_W-1:0] MAG_MAX = 24'sh7FFFFF;
    localparam logic signed [MAG_W-1:0] MAG_MIN = 24'sh800000;

    localparam logic [SIG_W-1:0]  SIGMA_RESET = 19'd13107;
    localparam logic [SIG_W-1:0]  SIGMA_SAT   = 19'd524287;
    localparam logic [SIGU_W-1:0] SIGMA_NONE  = 20'hF0000;

    // reciprocals of 5 for the constant divisions
    localparam logic [22:0] RECIP5_25 = 23'd6710887;
    localparam logic [26:0] RECIP5_29 = 27'd107374183;

    // shared divider
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 31;
    localparam int DIV_Q_W   = 26;
    localparam int DIV_CNT_W = 5;

    // square root unit
    localparam int SQ_W   = 48;
    localparam int SQ_R_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA_LOW  = 1'b0,
        CFG_SIGMA_HIGH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [MAG_W-1:0] station_mag;
        logic [WT_W-1:0]         station_weight;
        logic signed [MAG_W-1:0] average_mag;
        logic                    upper_side;
        logic                    last;
    } s_payload_t;

    typedef struct packed {
        logic signed [MAG_W-1:0]  net_mag;
        logic signed [SIGU_W-1:0] sigma_used;
        logic                     status;
    } m_payload_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] val;
    } sq_req_t;

    typedef struct packed {
        logic              done;
        logic [SQ_R_W-1:0] root;
    } sq_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIGMA,
        ST_SIGSQ,
        ST_PREP_RD,
        ST_PREP_SUM,
        ST_PREP_SQ,
        ST_PREP_WAIT,
        ST_ROUND,
        ST_ST_RD,
        ST_ST_Z,
        ST_ST_DIV,
        ST_ST_ROM,
        ST_ST_PHI,
        ST_ST_MUL,
        ST_EVAL,
        ST_SEC_MUL,
        ST_SEC_DIV,
        ST_SEC_WAIT,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

### rtl/bmcs_cdf_rom.sv
module bmcs_cdf_rom #(
    parameter int CDF_TABLE_DEPTH = bmcs_pkg::CDF_TABLE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic [$clog2(CDF_TABLE_DEPTH)-1:0]   addr_a,
    input  logic [$clog2(CDF_TABLE_DEPTH)-1:0]   addr_b,
    output logic [bmcs_pkg::PROB_W-1:0]          data_a,
    output logic [bmcs_pkg::PROB_W-1:0]          data_b
);

    localparam int          ZSTEP      = 524288 / CDF_TABLE_DEPTH;
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;
    localparam logic [63:0] INV_SQ2PI  = 64'd1713444048;

    typedef logic [CDF_TABLE_DEPTH-1:0][bmcs_pkg::PROB_W-1:0] cdf_rom_t;

    // exp(-x), Q32 in and out
    function automatic logic [63:0] exp_neg(input logic [63:0] x);
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] term;
        logic signed [63:0] acc;
        k    = x / LN2_Q32;
        r    = x - k * LN2_Q32;
        acc  = 64'sd1 <<< 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * r) >> 32) / 64'(n);
            if ((n % 2) == 1) acc = acc - $signed(term);
            else              acc = acc + $signed(term);
        end
        if (k >= 64'd40) return 64'd0;
        return $unsigned(acc) >> k;
    endfunction

    // Gaussian density, Q32, argument in Q17
    function automatic logic [63:0] density(input logic [63:0] z17);
        return (exp_neg((z17 * z17) >> 3) * INV_SQ2PI) >> 32;
    endfunction

    // Simpson integration of the density in Q48
    function automatic cdf_rom_t build_table();
        cdf_rom_t    tab;
        logic [63:0] acc;
        logic [63:0] h;
        logic [63:0] q;
        logic [63:0] a;
        acc = 64'd1 << 47;
        h   = 64'(ZSTEP);
        for (int i = 0; i < CDF_TABLE_DEPTH; i++) begin
            q = (acc + (64'd1 << 17)) >> 18;
            a = 64'd2 * 64'(i) * h;
            tab[i] = (q > 64'(bmcs_pkg::Q30_ONE)) ? bmcs_pkg::Q30_ONE
                                                   : bmcs_pkg::PROB_W'(q);
            acc = acc + h * (density(a) + 64'd4 * density(a + h)
                             + density(a + 64'd2 * h)) / 64'd6;
        end
        return tab;
    endfunction

    localparam cdf_rom_t CDF_ROM = build_table();

    always_ff @(posedge aclk) begin
        data_a <= CDF_ROM[addr_a];
        data_b <= CDF_ROM[addr_b];
    end

endmodule

### rtl/bmcs_div.sv
module bmcs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmcs_pkg::div_req_t req,
    output bmcs_pkg::div_rsp_t rsp
);

    localparam int NW = bmcs_pkg::DIV_NUM_W;
    localparam int DW = bmcs_pkg::DIV_DEN_W;
    localparam int QW = bmcs_pkg::DIV_Q_W;
    localparam int CW = bmcs_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic          ovf_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [DW-1:0] den_reg;

    logic          ovf_next;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    // quotient would not fit in QW bits
    assign ovf_next = {1'b0, req.num} >= {req.den, {QW{1'b0}}};
    assign rem_sh   = {rem_reg, quo_reg[QW-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_sub  = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= !ovf_next;
                done_reg <= ovf_next;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            ovf_reg <= ovf_next;
            den_reg <= req.den;
            rem_reg <= {1'b0, req.num[NW-1:QW]};
            quo_reg <= req.num[QW-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quo_reg;

endmodule

### rtl/bmcs_isqrt.sv
module bmcs_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmcs_pkg::sq_req_t req,
    output bmcs_pkg::sq_rsp_t rsp
);

    localparam int W = bmcs_pkg::SQ_W;

    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] trial;

    assign trial = r_reg + b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && b_reg == W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one result bit per cycle, highest even bit first
    always_ff @(posedge aclk) begin
        if (req.start) begin
            v_reg <= req.val;
            r_reg <= '0;
            b_reg <= W'(1) << (W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[bmcs_pkg::SQ_R_W-1:0];

endmodule

### rtl/bound_magnitude_confidence_search_top.sv
// Bound-magnitude confidence search.
// s_ channel: one station per transaction (bound magnitude, error weight).
// The transaction with last set also carries the average magnitude and the
// side and starts the search; it produces one m_ transaction with the
// magnitude found, the sigma used and a status (1 = iteration limit hit).
// Station transactions are stored in an on-chip memory; stations beyond
// MAX_STATIONS are dropped.
// Search steps: each weight is first turned into a deviation with the serial
// square root; each round then sends every station with a nonzero deviation
// through the serial divider (26 quotient bits), and a secant step, when one
// is taken, uses the same divider once more.
// s_ready is low from the last station until the result sits in the output
// register. A waiting result does not block loading of the next stations;
// the next search only stalls on completion until m_ready takes the held one.
// Reset (synchronous, aresetn low) empties the station count, drops any
// result and restores both sigma limits to 0.2; the Phi table is a ROM and
// needs no fill.
module bound_magnitude_confidence_search_top #(
    parameter int MAX_STATIONS    = bmcs_pkg::MAX_STATIONS_DEF,
    parameter int MAX_ITERATIONS  = bmcs_pkg::MAX_ITERATIONS_DEF,
    parameter int CDF_TABLE_DEPTH = bmcs_pkg::CDF_TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bmcs_pkg::s_payload_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bmcs_pkg::m_payload_t               m_data,
    input  logic                               cfg_wr_en,
    input  logic [bmcs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bmcs_pkg::SIG_W-1:0]         cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_STATIONS + 1);
    localparam int ADDR_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int IT_W   = $clog2(MAX_ITERATIONS + 1);
    localparam int ROM_AW = $clog2(CDF_TABLE_DEPTH);
    localparam int ZSH    = 19 - ROM_AW;
    localparam int ZSTEP  = 524288 / CDF_TABLE_DEPTH;
    localparam logic [bmcs_pkg::DIV_Q_W-1:0] SAT_A =
        bmcs_pkg::DIV_Q_W'((CDF_TABLE_DEPTH - 1) * ZSTEP);
    localparam int ENT_W  = bmcs_pkg::ENT_W;
    localparam int PW     = bmcs_pkg::PROB_W;

    function automatic logic signed [23:0] clamp_mag(input logic signed [27:0] v);
        if (v > 28'(bmcs_pkg::MAG_MAX)) return bmcs_pkg::MAG_MAX;
        if (v < 28'(bmcs_pkg::MAG_MIN)) return bmcs_pkg::MAG_MIN;
        return v[23:0];
    endfunction

    bmcs_pkg::state_t state_reg, state_next;

    // configuration
    logic [bmcs_pkg::SIG_W-1:0] sig_low_reg;
    logic [bmcs_pkg::SIG_W-1:0] sig_high_reg;

    // control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IT_W-1:0]  iter_reg;
    logic             m_valid_reg;

    // datapath
    logic                         side_reg;
    logic signed [12:0]           t_reg;
    logic                         have_reg;
    logic                         hit_reg;
    logic [bmcs_pkg::SIG_W-1:0]   sigma_reg;
    logic [37:0]                  sigsq_reg;
    logic [bmcs_pkg::SQ_W-1:0]    sum_reg;
    logic signed [23:0]           mu_reg;
    logic signed [23:0]           mu0_reg;
    logic [PW-1:0]                prob_reg;
    logic [PW-1:0]                prob0_reg;
    logic [PW-1:0]                p_reg;
    logic                         dneg_reg;
    logic                         zneg_reg;
    logic                         sat_reg;
    logic [ZSH-1:0]               frac_reg;
    logic [ROM_AW-1:0]            rom_a_reg;
    logic [ROM_AW-1:0]            rom_b_reg;
    logic signed [56:0]           sec_num_reg;
    logic signed [31:0]           sec_den_reg;
    bmcs_pkg::m_payload_t         m_data_reg;

    // station memory: magnitude and weight, later magnitude and deviation
    logic [ENT_W-1:0]  store_mem [MAX_STATIONS];
    logic [ENT_W-1:0]  rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [ENT_W-1:0]  mem_wd;

    bmcs_pkg::div_req_t div_req;
    bmcs_pkg::div_rsp_t div_rsp;
    bmcs_pkg::sq_req_t  sq_req;
    bmcs_pkg::sq_rsp_t  sq_rsp;
    logic [PW-1:0]      rom_a_data;
    logic [PW-1:0]      rom_b_data;

    logic s_fire;
    logic out_free;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // Combinational arithmetic
    // ---------------------------------------------------------------
    logic signed [23:0] st_mag;
    logic [23:0]        st_dev;
    logic signed [24:0] st_diff;
    logic signed [24:0] st_d;
    logic [23:0]        st_dabs;
    logic               hit;
    logic               step_lin;
    logic signed [28:0] ave20;
    logic [28:0]        ave20_abs;
    logic [12:0]        t_abs;
    logic [23:0]        k_mul;
    logic [24:0]        k_sum;
    logic [7:0]         k_val;
    logic [23:0]        sig_x;
    logic [44:0]        sig_p;
    logic [19:0]        sig_q;
    logic signed [13:0] u_val;
    logic [12:0]        u_abs;
    logic [53:0]        mu0_p;
    logic signed [27:0] mu0_s;
    logic signed [27:0] mu_step;
    logic [PW-1:0]      phi_v;
    logic [PW+ZSH-1:0]  interp_p;
    logic [61:0]        prob_p;
    logic signed [24:0] sec_dmu;
    logic signed [31:0] sec_dp;
    logic [55:0]        sec_num_abs;
    logic [30:0]        sec_den_abs;
    logic               sec_qneg;
    logic signed [27:0] sec_mu;

    always_comb begin
        st_mag  = rd_reg[ENT_W-1:bmcs_pkg::DEV_W];
        st_dev  = rd_reg[bmcs_pkg::DEV_W-1:0];
        st_diff = {mu_reg[23], mu_reg} - {st_mag[23], st_mag};
        st_d    = side_reg ? st_diff : -st_diff;
        st_dabs = st_d[24] ? 24'(-st_d) : st_d[23:0];

        hit      = (prob_reg > bmcs_pkg::P_LO) && (prob_reg < bmcs_pkg::P_HI);
        step_lin = (prob_reg < bmcs_pkg::P_90) || (prob_reg == prob0_reg);

        // t = trunc(20 * average), toward zero
        ave20     = $signed({{5{s_data.average_mag[23]}}, s_data.average_mag}) * 29'sd20;
        ave20_abs = ave20[28] ? 29'(-ave20) : ave20;
        t_abs     = ave20_abs[28:16];

        // sigma = round(k * 65536 / 20), k = ceil(20 * high / 65536)
        k_mul = {5'd0, sig_high_reg} * 24'd20;
        k_sum = {1'b0, k_mul} + 25'd65535;
        k_val = k_sum[23:16];
        sig_x = {k_val, 16'd0} + 24'd10;
        sig_p = sig_x[23:2] * bmcs_pkg::RECIP5_25;
        sig_q = sig_p[44:25];

        // mu0 = trunc((t - 5s) * 65536 / 20)
        u_val  = {t_reg[12], t_reg} - (side_reg ? 14'sd5 : -14'sd5);
        u_abs  = u_val[13] ? 13'(-u_val) : u_val[12:0];
        mu0_p  = {u_abs, 14'd0} * bmcs_pkg::RECIP5_29;
        mu0_s  = u_val[13] ? -$signed({4'd0, mu0_p[52:29]})
                           : $signed({4'd0, mu0_p[52:29]});

        mu_step = {{4{mu_reg[23]}}, mu_reg}
                  + (side_reg ? bmcs_pkg::STEP01 : -bmcs_pkg::STEP01);

        interp_p = (rom_b_data - rom_a_data) * frac_reg;
        phi_v    = sat_reg ? rom_a_data : rom_a_data + interp_p[PW+ZSH-1:ZSH];

        prob_p = prob_reg * p_reg;

        sec_dmu     = {mu_reg[23], mu_reg} - {mu0_reg[23], mu0_reg};
        sec_dp      = $signed({1'b0, prob_reg}) - $signed({1'b0, bmcs_pkg::P_95});
        sec_num_abs = sec_num_reg[56] ? 56'(-sec_num_reg) : sec_num_reg[55:0];
        sec_den_abs = sec_den_reg[31] ? 31'(-sec_den_reg) : sec_den_reg[30:0];
        sec_qneg    = sec_num_reg[56] ^ sec_den_reg[31];
        sec_mu      = sec_qneg
                      ? {{4{mu_reg[23]}}, mu_reg} + $signed({2'd0, div_rsp.quot})
                      : {{4{mu_reg[23]}}, mu_reg} - $signed({2'd0, div_rsp.quot});
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bmcs_pkg::ST_IDLE: begin
                if (s_fire && s_data.last) state_next = bmcs_pkg::ST_SIGMA;
            end
            bmcs_pkg::ST_SIGMA: begin
                if (sig_low_reg != sig_high_reg && k_val == 8'd0)
                    state_next = bmcs_pkg::ST_DONE;
                else
                    state_next = bmcs_pkg::ST_SIGSQ;
            end
            bmcs_pkg::ST_SIGSQ: begin
                state_next = (count_reg == '0) ? bmcs_pkg::ST_ROUND
                                               : bmcs_pkg::ST_PREP_RD;
            end
            bmcs_pkg::ST_PREP_RD:  state_next = bmcs_pkg::ST_PREP_SUM;
            bmcs_pkg::ST_PREP_SUM: state_next = bmcs_pkg::ST_PREP_SQ;
            bmcs_pkg::ST_PREP_SQ:  state_next = bmcs_pkg::ST_PREP_WAIT;
            bmcs_pkg::ST_PREP_WAIT: begin
                if (sq_rsp.done)
                    state_next = (idx_reg + CNT_W'(1) == count_reg)
                                 ? bmcs_pkg::ST_ROUND : bmcs_pkg::ST_PREP_RD;
            end
            bmcs_pkg::ST_ROUND: begin
                state_next = (count_reg == '0) ? bmcs_pkg::ST_EVAL
                                               : bmcs_pkg::ST_ST_RD;
            end
            bmcs_pkg::ST_ST_RD: state_next = bmcs_pkg::ST_ST_Z;
            bmcs_pkg::ST_ST_Z: begin
                state_next = (st_dev == '0) ? bmcs_pkg::ST_ST_MUL
                                            : bmcs_pkg::ST_ST_DIV;
            end
            bmcs_pkg::ST_ST_DIV: begin
                if (div_rsp.done) state_next = bmcs_pkg::ST_ST_ROM;
            end
            bmcs_pkg::ST_ST_ROM: state_next = bmcs_pkg::ST_ST_PHI;
            bmcs_pkg::ST_ST_PHI: state_next = bmcs_pkg::ST_ST_MUL;
            bmcs_pkg::ST_ST_MUL: begin
                state_next = (idx_reg + CNT_W'(1) == count_reg)
                             ? bmcs_pkg::ST_EVAL : bmcs_pkg::ST_ST_RD;
            end
            bmcs_pkg::ST_EVAL: begin
                priority if (hit)  state_next = bmcs_pkg::ST_DONE;
                else if (step_lin) state_next = bmcs_pkg::ST_NEXT;
                else               state_next = bmcs_pkg::ST_SEC_MUL;
            end
            bmcs_pkg::ST_SEC_MUL: state_next = bmcs_pkg::ST_SEC_DIV;
            bmcs_pkg::ST_SEC_DIV: state_next = bmcs_pkg::ST_SEC_WAIT;
            bmcs_pkg::ST_SEC_WAIT: begin
                if (div_rsp.done) state_next = bmcs_pkg::ST_NEXT;
            end
            bmcs_pkg::ST_NEXT: begin
                state_next = (iter_reg == IT_W'(MAX_ITERATIONS - 1))
                             ? bmcs_pkg::ST_DONE : bmcs_pkg::ST_ROUND;
            end
            bmcs_pkg::ST_DONE: begin
                if (out_free) state_next = bmcs_pkg::ST_IDLE;
            end
            default: state_next = bmcs_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Control outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_ready      = (state_reg == bmcs_pkg::ST_IDLE);
        mem_we       = 1'b0;
        mem_wa       = idx_reg[ADDR_W-1:0];
        mem_wd       = {st_mag, sq_rsp.root};
        div_req      = '0;
        sq_req.start = (state_reg == bmcs_pkg::ST_PREP_SQ);
        sq_req.val   = sum_reg;
        unique case (state_reg)
            bmcs_pkg::ST_IDLE: begin
                // store while there is room; drop the rest
                mem_we = s_fire && (count_reg < CNT_W'(MAX_STATIONS));
                mem_wa = count_reg[ADDR_W-1:0];
                mem_wd = {s_data.station_mag, 1'b0, s_data.station_weight};
            end
            bmcs_pkg::ST_PREP_WAIT: begin
                // write the deviation back over the weight
                mem_we = sq_rsp.done;
            end
            bmcs_pkg::ST_ST_Z: begin
                div_req.start = (st_dev != '0);
                div_req.num   = {16'd0, st_dabs, 16'd0};
                div_req.den   = {7'd0, st_dev};
            end
            bmcs_pkg::ST_SEC_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = sec_num_abs;
                div_req.den   = sec_den_abs;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Memory, one write and one registered read per cycle
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) store_mem[mem_wa] <= mem_wd;
        rd_reg <= store_mem[idx_reg[ADDR_W-1:0]];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bmcs_pkg::ST_IDLE;
            sig_low_reg  <= bmcs_pkg::SIGMA_RESET;
            sig_high_reg <= bmcs_pkg::SIGMA_RESET;
            count_reg    <= '0;
            idx_reg      <= '0;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_addr == bmcs_pkg::CFG_SIGMA_LOW) sig_low_reg  <= cfg_wdata;
                else                                     sig_high_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                bmcs_pkg::ST_IDLE: begin
                    if (s_fire && count_reg < CNT_W'(MAX_STATIONS))
                        count_reg <= count_reg + CNT_W'(1);
                end
                bmcs_pkg::ST_SIGSQ: begin
                    idx_reg  <= '0;
                    iter_reg <= '0;
                end
                bmcs_pkg::ST_PREP_WAIT: begin
                    if (sq_rsp.done) idx_reg <= idx_reg + CNT_W'(1);
                end
                bmcs_pkg::ST_ROUND: idx_reg <= '0;
                bmcs_pkg::ST_ST_MUL: idx_reg <= idx_reg + CNT_W'(1);
                bmcs_pkg::ST_NEXT:   iter_reg <= iter_reg + IT_W'(1);
                bmcs_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        count_reg   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bmcs_pkg::ST_IDLE: begin
                if (s_fire && s_data.last) begin
                    side_reg <= s_data.upper_side;
                    t_reg    <= ave20[28] ? -$signed(t_abs) : $signed(t_abs);
                end
            end
            bmcs_pkg::ST_SIGMA: begin
                hit_reg <= 1'b0;
                if (sig_low_reg == sig_high_reg) begin
                    sigma_reg <= sig_low_reg;
                    have_reg  <= 1'b1;
                end else begin
                    sigma_reg <= (sig_q > {1'b0, bmcs_pkg::SIGMA_SAT})
                                 ? bmcs_pkg::SIGMA_SAT : sig_q[18:0];
                    have_reg  <= (k_val != 8'd0);
                end
                mu0_reg <= clamp_mag(mu0_s);
            end
            bmcs_pkg::ST_SIGSQ: begin
                sigsq_reg <= sigma_reg * sigma_reg;
                mu_reg    <= clamp_mag({{4{mu0_reg[23]}}, mu0_reg}
                             + (side_reg ? bmcs_pkg::STEP005 : -bmcs_pkg::STEP005));
                prob0_reg <= bmcs_pkg::Q30_ONE;
            end
            bmcs_pkg::ST_PREP_SUM: begin
                sum_reg <= {10'd0, sigsq_reg}
                           + 48'(rd_reg[bmcs_pkg::WT_W-1:0] * rd_reg[bmcs_pkg::WT_W-1:0]);
            end
            bmcs_pkg::ST_ROUND: prob_reg <= bmcs_pkg::Q30_ONE;
            bmcs_pkg::ST_ST_Z: begin
                dneg_reg <= st_d[24];
                // zero deviation: step function
                if (st_d == '0)     p_reg <= bmcs_pkg::Q30_HALF;
                else if (st_d[24])  p_reg <= '0;
                else                p_reg <= bmcs_pkg::Q30_ONE;
            end
            bmcs_pkg::ST_ST_DIV: begin
                if (div_rsp.done) begin
                    sat_reg  <= div_rsp.ovf || (div_rsp.quot >= SAT_A);
                    frac_reg <= div_rsp.quot[ZSH-1:0];
                    zneg_reg <= dneg_reg && (div_rsp.ovf || div_rsp.quot != '0);
                    if (div_rsp.ovf || div_rsp.quot >= SAT_A) begin
                        rom_a_reg <= ROM_AW'(CDF_TABLE_DEPTH - 1);
                        rom_b_reg <= ROM_AW'(CDF_TABLE_DEPTH - 1);
                    end else begin
                        rom_a_reg <= div_rsp.quot[ZSH+ROM_AW-1:ZSH];
                        rom_b_reg <= div_rsp.quot[ZSH+ROM_AW-1:ZSH] + ROM_AW'(1);
                    end
                end
            end
            bmcs_pkg::ST_ST_PHI: begin
                p_reg <= zneg_reg ? bmcs_pkg::Q30_ONE - phi_v : phi_v;
            end
            bmcs_pkg::ST_ST_MUL: prob_reg <= prob_p[60:30];
            bmcs_pkg::ST_EVAL: begin
                hit_reg <= hit;
                if (!hit && step_lin) begin
                    mu_reg    <= clamp_mag(mu_step);
                    mu0_reg   <= mu_reg;
                    prob0_reg <= prob_reg;
                end
            end
            bmcs_pkg::ST_SEC_MUL: begin
                sec_num_reg <= sec_dmu * sec_dp;
                sec_den_reg <= $signed({1'b0, prob_reg}) - $signed({1'b0, prob0_reg});
            end
            bmcs_pkg::ST_SEC_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.ovf)
                        mu_reg <= sec_qneg ? bmcs_pkg::MAG_MAX : bmcs_pkg::MAG_MIN;
                    else
                        mu_reg <= clamp_mag(sec_mu);
                    mu0_reg   <= mu_reg;
                    prob0_reg <= prob_reg;
                end
            end
            bmcs_pkg::ST_DONE: begin
                if (out_free) begin
                    m_data_reg.net_mag    <= have_reg ? mu_reg : '0;
                    m_data_reg.sigma_used <= have_reg ? $signed({1'b0, sigma_reg})
                                                      : bmcs_pkg::SIGMA_NONE;
                    m_data_reg.status     <= have_reg && !hit_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    bmcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bmcs_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    bmcs_cdf_rom #(
        .CDF_TABLE_DEPTH (CDF_TABLE_DEPTH)
    ) u_cdf_rom (
        .aclk   (aclk),
        .addr_a (rom_a_reg),
        .addr_b (rom_b_reg),
        .data_a (rom_a_data),
        .data_b (rom_b_data)
    );

endmodule
